// File: rtl/qeb_pkg.sv
// Shared constants, codes, types and the Gray-code step table for the encoder block.
package qeb_pkg;

	// Field and state widths
	localparam int TIME_WIDTH       = 48;
	localparam int COUNT_WIDTH      = 32;
	localparam int POS_WIDTH        = 32;
	localparam int STAMP_WIDTH      = 39;
	localparam int CMD_WIDTH        = 3;
	localparam int KIND_WIDTH       = 3;
	localparam int LONG_PRESS_WIDTH = 16;
	localparam int DEBOUNCE_WIDTH   = 20;
	localparam int CFG_DATA_WIDTH   = 20;
	localparam int CFG_INDEX_WIDTH  = 2;

	// Microseconds per millisecond and the long-press threshold in microseconds
	localparam int MS_DIV    = 1000;
	localparam int THR_WIDTH = 26;
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1000 * MS_DIV);
	localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(5000);

	// Millisecond stamp: long division by 1000, one 16-bit chunk per step pair
	localparam int CHUNK_WIDTH = 16;
	localparam int NUM_CHUNKS  = (TIME_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
	localparam int PAD_WIDTH   = NUM_CHUNKS * CHUNK_WIDTH;
	localparam int REM_WIDTH   = 10;
	localparam int X_WIDTH     = REM_WIDTH + CHUNK_WIDTH;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_WIDTH = 27;
	localparam int PROD_WIDTH  = X_WIDTH + RECIP_WIDTH;
	localparam logic [RECIP_WIDTH-1:0] RECIP =
		RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'(MS_DIV) - 64'd1) / 64'(MS_DIV));
	localparam int NUM_STAGES  = 2 * NUM_CHUNKS - 1;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_POLL   = 3'd0,
		CMD_ROTATE = 3'd1,
		CMD_BUTTON = 3'd2,
		CMD_SYNC   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [KIND_WIDTH-1:0] {
		EVT_CW      = 3'd0,
		EVT_CCW     = 3'd1,
		EVT_PRESS   = 3'd2,
		EVT_RELEASE = 3'd3,
		EVT_LONG    = 3'd4
	} event_kind_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_LONG_PRESS = 2'd0,
		CFG_DEBOUNCE   = 2'd1,
		CFG_BUTTON_EN  = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// One stage of the stamp pipeline: event payload plus division progress
	typedef struct packed {
		event_kind_t            kind;
		logic [POS_WIDTH-1:0]   pos;
		logic                   held;
		logic [PAD_WIDTH-1:0]   now;
		logic [PAD_WIDTH-1:0]   quot;
		logic [X_WIDTH-1:0]     x;
		logic [REM_WIDTH-1:0]   rem;
	} stamp_stage_t;

	// x4 decode of old and new phase pair
	function automatic step_t gray_step(input logic [1:0] old_pair, input logic [1:0] new_pair);
		step_t step;
		case ({old_pair, new_pair}) inside
			4'b0010, 4'b0100, 4'b1011, 4'b1101: step = STEP_UP;
			4'b0001, 4'b0111, 4'b1000, 4'b1110: step = STEP_DOWN;
			default:                            step = STEP_NONE;
		endcase
		return step;
	endfunction

endpackage

// File: rtl/qeb_intf.sv
// Handshake channel interfaces: request items, event items and register writes.
interface qeb_req_if import qeb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_WIDTH-1:0]  cmd;
	logic [TIME_WIDTH-1:0] now_us;
	logic                  phase_a;
	logic                  phase_b;
	logic                  switch_level;

	modport source (output valid, cmd, now_us, phase_a, phase_b, switch_level, input ready);
	modport sink   (input valid, cmd, now_us, phase_a, phase_b, switch_level, output ready);
endinterface

interface qeb_evt_if import qeb_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [KIND_WIDTH-1:0]         event_kind;
	logic signed [POS_WIDTH-1:0]   position_now;
	logic [STAMP_WIDTH-1:0]        stamp_ms;
	logic                          held;

	modport source (output valid, event_kind, position_now, stamp_ms, held, input ready);
	modport sink   (input valid, event_kind, position_now, stamp_ms, held, output ready);
endinterface

interface qeb_cfg_if import qeb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/qeb_stamp_pipe.sv
// Event pipeline that divides the item time by 1000 into a millisecond stamp.
module qeb_stamp_pipe import qeb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  stamp_stage_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output stamp_stage_t out_data
);

	stamp_stage_t pipe_q     [NUM_STAGES];
	logic         pipe_vld_q [NUM_STAGES];
	logic         stall      [NUM_STAGES];

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		localparam int CHUNK    = k / 2;
		localparam bit REM_STEP = (k % 2) == 1;
		localparam int LSB      = (NUM_CHUNKS - 1 - CHUNK) * CHUNK_WIDTH;

		stamp_stage_t           prv;
		stamp_stage_t           nxt;
		logic                   prv_vld;
		logic [PROD_WIDTH-1:0]  prod;
		logic [X_WIDTH-1:0]     qk;

		// Pick the upstream stage
		if (k == 0) begin : g_head
			assign prv     = in_data;
			assign prv_vld = in_valid;
		end else begin : g_body
			assign prv     = pipe_q[k-1];
			assign prv_vld = pipe_vld_q[k-1];
		end

		// Hold while occupied and the stage after is blocked
		if (k == NUM_STAGES - 1) begin : g_tail
			assign stall[k] = pipe_vld_q[k] & ~out_ready;
		end else begin : g_mid
			assign stall[k] = pipe_vld_q[k] & stall[k+1];
		end

		// Quotient digit by reciprocal multiply, or remainder for the next chunk
		always_comb begin
			nxt  = prv;
			prod = '0;
			qk   = '0;
			if (REM_STEP) begin
				qk      = X_WIDTH'(prv.quot[LSB +: CHUNK_WIDTH]);
				nxt.rem = REM_WIDTH'(prv.x - qk * X_WIDTH'(MS_DIV));
			end else begin
				nxt.x    = {prv.rem, prv.now[LSB +: CHUNK_WIDTH]};
				prod     = PROD_WIDTH'(nxt.x) * PROD_WIDTH'(RECIP);
				nxt.quot[LSB +: CHUNK_WIDTH] = prod[RECIP_SHIFT +: CHUNK_WIDTH];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_vld_q[k] <= 1'b0;
			end else if (!stall[k]) begin
				pipe_vld_q[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (!stall[k]) begin
				pipe_q[k] <= nxt;
			end
		end
	end

	assign in_ready  = ~stall[0];
	assign out_valid = pipe_vld_q[NUM_STAGES-1];
	assign out_data  = pipe_q[NUM_STAGES-1];

endmodule

// File: rtl/quadrature_encoder_with_button.sv
// Top level: quadrature encoder and push-button event decoder.
//
// Channels: req carries one timestamped item (poll, rotation edge, button
// edge, pin-pair sync or position clear); evt carries at most one event
// item per request (clockwise, counter-clockwise, press, release, long
// press) with the position, the millisecond stamp and the held flag; cfg
// writes long_press_ms (index 0), debounce_us (1) and button_enable (2).
// cfg.ready is always high; write registers only while the block is idle.
// Throughput: one request per cycle while req.ready is high. Decoding and
// state update take place in the input stage; the millisecond stamp then
// passes five stages of long division by 1000 (three 16-bit chunks, a
// reciprocal multiply per chunk and a remainder step for each chunk but the
// last), each stage registered. Requests that give no event drop out after
// the input stage.
// Stall: a blocked evt holds the output stage; earlier stages keep filling
// bubbles, and req.ready falls once the path to the output is full.
// Reset (arst_n low): position, pair, times and button state go to zero,
// registers to 1000 ms, 5000 us and button enabled; all stages empty.
module quadrature_encoder_with_button import qeb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	qeb_req_if.sink    req,
	qeb_evt_if.source  evt,
	qeb_cfg_if.sink    cfg
);

	// Configuration
	logic [THR_WIDTH-1:0]      thr_q;
	logic [DEBOUNCE_WIDTH-1:0] debounce_q;
	logic                      button_en_q;

	// Input stage
	logic                  req_vld_s1;
	logic [CMD_WIDTH-1:0]  cmd_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic [1:0]            pair_s1;
	logic                  sw_s1;

	// Decoder state
	logic [COUNT_WIDTH-1:0] count_q,       count_d;
	logic [1:0]             prev_pair_q,   prev_pair_d;
	logic [TIME_WIDTH-1:0]  last_edge_q,   last_edge_d;
	logic                   pressed_q,     pressed_d;
	logic [TIME_WIDTH-1:0]  press_start_q, press_start_d;
	logic                   long_done_q,   long_done_d;

	logic                  emit;
	event_kind_t           kind_d;
	logic [TIME_WIDTH-1:0] gap;
	logic [TIME_WIDTH-1:0] hold_time;
	logic                  s1_fire;
	logic                  pipe_in_ready;
	stamp_stage_t          pipe_in;
	stamp_stage_t          pipe_out;

	// Register writes; keep the threshold in microseconds
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			debounce_q  <= DEBOUNCE_RESET;
			button_en_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_LONG_PRESS: thr_q <= THR_WIDTH'(cfg.data[LONG_PRESS_WIDTH-1:0])
					* THR_WIDTH'(MS_DIV);
				CFG_DEBOUNCE:   debounce_q  <= cfg.data[DEBOUNCE_WIDTH-1:0];
				CFG_BUTTON_EN:  button_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input stage: advance when empty or when its item moves on
	assign req.ready = ~req_vld_s1 | pipe_in_ready;
	assign s1_fire   = req_vld_s1 & pipe_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req.ready) begin
			req_vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			now_s1  <= req.now_us;
			pair_s1 <= {req.phase_a, req.phase_b};
			sw_s1   <= req.switch_level;
		end
	end

	// Decode the item against the current state
	assign gap       = now_s1 - last_edge_q;
	assign hold_time = now_s1 - press_start_q;

	always_comb begin
		count_d       = count_q;
		prev_pair_d   = prev_pair_q;
		last_edge_d   = last_edge_q;
		pressed_d     = pressed_q;
		press_start_d = press_start_q;
		long_done_d   = long_done_q;
		emit          = 1'b0;
		kind_d        = EVT_CW;
		unique case (cmd_t'(cmd_s1))
			CMD_POLL: begin
				if (pressed_q && !long_done_q && hold_time >= TIME_WIDTH'(thr_q)) begin
					long_done_d = 1'b1;
					emit        = 1'b1;
					kind_d      = EVT_LONG;
				end
			end
			CMD_ROTATE: begin
				if (gap >= TIME_WIDTH'(debounce_q)) begin
					last_edge_d = now_s1;
					prev_pair_d = pair_s1;
					case (gray_step(prev_pair_q, pair_s1))
						STEP_UP: begin
							count_d = count_q + 1'b1;
							emit    = 1'b1;
							kind_d  = EVT_CW;
						end
						STEP_DOWN: begin
							count_d = count_q - 1'b1;
							emit    = 1'b1;
							kind_d  = EVT_CCW;
						end
						default: ;
					endcase
				end
			end
			CMD_BUTTON: begin
				if (button_en_q) begin
					if (!sw_s1 && !pressed_q) begin
						pressed_d     = 1'b1;
						press_start_d = now_s1;
						long_done_d   = 1'b0;
						emit          = 1'b1;
						kind_d        = EVT_PRESS;
					end else if (sw_s1 && pressed_q) begin
						pressed_d = 1'b0;
						emit      = 1'b1;
						kind_d    = EVT_RELEASE;
					end
				end
			end
			CMD_SYNC:  prev_pair_d = pair_s1;
			CMD_CLEAR: count_d     = '0;
			default: ;
		endcase
	end

	// Commit state as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			prev_pair_q   <= '0;
			last_edge_q   <= '0;
			pressed_q     <= 1'b0;
			press_start_q <= '0;
			long_done_q   <= 1'b0;
		end else if (s1_fire) begin
			count_q       <= count_d;
			prev_pair_q   <= prev_pair_d;
			last_edge_q   <= last_edge_d;
			pressed_q     <= pressed_d;
			press_start_q <= press_start_d;
			long_done_q   <= long_done_d;
		end
	end

	// Event payload into the stamp pipeline
	always_comb begin
		pipe_in      = '0;
		pipe_in.kind = kind_d;
		pipe_in.pos  = POS_WIDTH'(signed'(count_d));
		pipe_in.held = pressed_d;
		pipe_in.now  = PAD_WIDTH'(now_s1);
	end

	qeb_stamp_pipe u_stamp_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_vld_s1 & emit),
		.in_ready  (pipe_in_ready),
		.in_data   (pipe_in),
		.out_valid (evt.valid),
		.out_ready (evt.ready),
		.out_data  (pipe_out)
	);

	assign evt.event_kind   = pipe_out.kind;
	assign evt.position_now = signed'(pipe_out.pos);
	assign evt.stamp_ms     = STAMP_WIDTH'(pipe_out.quot);
	assign evt.held         = pipe_out.held;

	// Checks
	a_long_held: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_kind == EVT_LONG |-> evt.held)
		else $error("long press reported without the button held");

	a_button_held: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && (evt.event_kind == EVT_PRESS || evt.event_kind == EVT_RELEASE)
		|-> evt.held == (evt.event_kind == EVT_PRESS))
		else $error("held flag disagrees with button event");

	a_ready_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> req_vld_s1)
		else $error("request blocked with an empty input stage");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && cmd_s1 == CMD_CLEAR |=> count_q == '0)
		else $error("position not cleared");

	a_step_up: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && emit && kind_d == EVT_CW
		|=> count_q == COUNT_WIDTH'($past(count_q) + 1'b1))
		else $error("clockwise event without position increment");

endmodule
